// ----- rtl/core/tcw_pkg.sv -----
// Package for the text console writer: shared types and constants.
package tcw_pkg;

    localparam int IDX_W = 11;
    localparam int POS_W = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] RESET_COLOR = 8'h0F;
    localparam logic [15:0] RESET_CELL = 16'h0F20;

    typedef enum logic [2:0] {
        OP_READ,
        OP_NL,
        OP_CR,
        OP_TAB,
        OP_BS,
        OP_CHAR
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_TAB,
        S_CHECK,
        S_SCRL,
        S_FILL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] read_index;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_back_ctl;

endpackage

// ----- rtl/core/text_console_writer_core.sv -----
// Top level of the text console writer: color register, front queue and back sequencer.
// A put that scrolls adds a copy sweep, which moves every row up, and a fill of the bottom row.
// The back sequencer takes one request at a time and finishes it before it takes the next.
// Reset: synchronous, active low; a clear pass writes every cell to space on white-on-black,
// with full held high until it ends.
module text_console_writer_core #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_cmd,
    input  logic [7:0]                 i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]  i_read_index,
    output logic                       empty,
    input  logic                       pop,
    output logic [tcw_pkg::CELL_W-1:0] o_cell_value,
    output logic [tcw_pkg::POS_W-1:0]  o_caret_pos,
    output logic                       o_scrolled,
    input  logic                       i_cfg_we,
    input  logic [7:0]                 i_cfg_data
);

    // attribute byte used for written and cleared cells
    logic [7:0] r_color;

    tcw_pkg::t_head     head;
    tcw_pkg::t_back_ctl ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tcw_pkg::RESET_COLOR;
        end else if (i_cfg_we) begin
            r_color <= i_cfg_data;
        end
    end

    // front: decode the request and queue up to two so the sender can run ahead of a sweep
    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .i_ctl        (ctl),
        .o_head       (head)
    );

    // back: cursor, screen memory, scroll and the one-entry result queue
    tcw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_color      (r_color),
        .i_head       (head),
        .o_ctl        (ctl),
        .empty        (empty),
        .pop          (pop),
        .o_cell_value (o_cell_value),
        .o_caret_pos  (o_caret_pos),
        .o_scrolled   (o_scrolled)
    );

endmodule

// ----- rtl/core/tcw_front.sv -----
// Front end: classifies incoming requests and holds them in a two-entry queue.
module tcw_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_cmd,
    input  logic [7:0]               i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0] i_read_index,
    input  tcw_pkg::t_back_ctl       i_ctl,
    output tcw_pkg::t_head           o_head
);

    tcw_pkg::t_cmd r_slot [2];
    logic          r_rd, n_rd;
    logic          r_wr, n_wr;
    logic [1:0]    r_cnt, n_cnt;
    tcw_pkg::t_cmd new_cmd;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        new_cmd.char_code  = i_char_code;
        new_cmd.read_index = i_read_index;
        if (i_cmd) begin
            new_cmd.op = tcw_pkg::OP_READ;
        end else begin
            case (i_char_code)
                tcw_pkg::CH_NL:  new_cmd.op = tcw_pkg::OP_NL;
                tcw_pkg::CH_CR:  new_cmd.op = tcw_pkg::OP_CR;
                tcw_pkg::CH_TAB: new_cmd.op = tcw_pkg::OP_TAB;
                tcw_pkg::CH_BS:  new_cmd.op = tcw_pkg::OP_BS;
                default:         new_cmd.op = tcw_pkg::OP_CHAR;
            endcase
        end
    end

    assign full    = (r_cnt == 2'd2) || i_ctl.clearing;
    assign do_push = push && !full;
    assign do_pop  = i_ctl.take && (r_cnt != 2'd0);

    always_comb begin
        n_rd  = r_rd ^ do_pop;
        n_wr  = r_wr ^ do_push;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= new_cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_slot[r_rd];

endmodule

// ----- rtl/core/tcw_back.sv -----
// Back end: cursor sequencer, screen memory, scroll and clear sweeps, result register.
module tcw_back #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_color,
    input  tcw_pkg::t_head            i_head,
    output tcw_pkg::t_back_ctl        o_ctl,
    output logic                      empty,
    input  logic                      pop,
    output logic [tcw_pkg::CELL_W-1:0] o_cell_value,
    output logic [tcw_pkg::POS_W-1:0]  o_caret_pos,
    output logic                      o_scrolled
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int PTR_W    = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(COLUMNS + 1);
    localparam int ROW_W    = $clog2(ROWS + 1);
    localparam int MOD_W    = $clog2(TAB_STOP + 1);
    localparam int MOD_LAST = (COLUMNS - 1) % TAB_STOP;

    logic [tcw_pkg::CELL_W-1:0] r_mem [CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    tcw_pkg::t_state            r_state, n_state;
    logic [COL_W-1:0]           r_col, n_col;
    logic [ROW_W-1:0]           r_row, n_row;
    logic [MOD_W-1:0]           r_mod, n_mod;
    logic [PTR_W-1:0]           r_ptr, n_ptr;
    logic                       r_inrange, n_inrange;
    logic                       r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0]          r_wr_addr, n_wr_addr;
    logic [tcw_pkg::CELL_W-1:0] r_res_cell, n_res_cell;
    logic                       r_res_scr, n_res_scr;
    logic                       r_out_valid, n_out_valid;
    logic [tcw_pkg::CELL_W-1:0] r_out_cell, n_out_cell;
    logic [tcw_pkg::POS_W-1:0]  r_out_pos, n_out_pos;
    logic                       r_out_scr, n_out_scr;

    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic [tcw_pkg::CELL_W-1:0] wdata;
    logic [ADDR_W-1:0]          raddr;
    logic [ADDR_W-1:0]          lin;
    logic [tcw_pkg::CELL_W-1:0] blank;
    logic                       take;
    logic                       wrap;
    logic [ROW_W-1:0]           row_wr;
    logic [MOD_W-1:0]           mod_inc;
    logic [MOD_W-1:0]           mod_dec;

    assign lin     = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign blank   = {i_color, tcw_pkg::CH_SPACE};
    assign mod_inc = (r_mod == MOD_W'(TAB_STOP - 1)) ? '0 : r_mod + 1'b1;
    assign mod_dec = (r_mod == '0) ? MOD_W'(TAB_STOP - 1) : r_mod - 1'b1;
    assign wrap    = (r_col == COL_W'(COLUMNS));
    assign row_wr  = r_row + ROW_W'(wrap);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_mod       = r_mod;
        n_ptr       = r_ptr;
        n_inrange   = r_inrange;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_res_cell  = r_res_cell;
        n_res_scr   = r_res_scr;
        n_out_valid = r_out_valid && !pop;
        n_out_cell  = r_out_cell;
        n_out_pos   = r_out_pos;
        n_out_scr   = r_out_scr;
        we          = 1'b0;
        waddr       = lin;
        wdata       = blank;
        raddr       = ADDR_W'(i_head.cmd.read_index);
        take        = 1'b0;

        case (r_state)
            tcw_pkg::S_CLEAR: begin
                we    = 1'b1;
                waddr = ADDR_W'(r_ptr);
                wdata = tcw_pkg::RESET_CELL;
                if (r_ptr == PTR_W'(CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = tcw_pkg::S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            tcw_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    take       = 1'b1;
                    n_res_cell = '0;
                    n_res_scr  = 1'b0;
                    n_state    = tcw_pkg::S_CHECK;
                    case (i_head.cmd.op)
                        tcw_pkg::OP_READ: begin
                            n_inrange = (32'(i_head.cmd.read_index) < CELLS);
                            n_state   = tcw_pkg::S_RDWAIT;
                        end
                        tcw_pkg::OP_NL: begin
                            n_col = '0;
                            n_mod = '0;
                            n_row = r_row + 1'b1;
                        end
                        tcw_pkg::OP_CR: begin
                            n_col = '0;
                            n_mod = '0;
                        end
                        tcw_pkg::OP_TAB: begin
                            n_state = tcw_pkg::S_TAB;
                        end
                        tcw_pkg::OP_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                                n_mod = mod_dec;
                                we    = 1'b1;
                                waddr = lin - 1'b1;
                            end else if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                                n_col = COL_W'(COLUMNS - 1);
                                n_mod = MOD_W'(MOD_LAST);
                                we    = 1'b1;
                                waddr = lin - 1'b1;
                            end
                        end
                        default: begin
                            we    = 1'b1;
                            wdata = {i_color, i_head.cmd.char_code};
                            n_col = r_col + 1'b1;
                            n_mod = mod_inc;
                        end
                    endcase
                end
            end
            tcw_pkg::S_RDWAIT: begin
                n_res_cell = r_inrange ? r_rd_data : '0;
                n_state    = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_TAB: begin
                we    = 1'b1;
                n_col = r_col + 1'b1;
                n_mod = mod_inc;
                if ((r_mod == MOD_W'(TAB_STOP - 1)) || (r_col == COL_W'(COLUMNS - 1))) begin
                    n_state = tcw_pkg::S_CHECK;
                end
            end
            tcw_pkg::S_CHECK: begin
                if (wrap) begin
                    n_col = '0;
                    n_mod = '0;
                    n_row = row_wr;
                end
                if (row_wr >= ROW_W'(ROWS)) begin
                    n_ptr   = '0;
                    n_state = tcw_pkg::S_SCRL;
                end else begin
                    n_state = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_SCRL: begin
                // read one row ahead, write the registered data back in the next cycle
                if (r_ptr == PTR_W'(CELLS - COLUMNS)) begin
                    n_state = tcw_pkg::S_FILL;
                end else begin
                    raddr     = ADDR_W'(r_ptr) + ADDR_W'(COLUMNS);
                    n_wr_pend = 1'b1;
                    n_wr_addr = ADDR_W'(r_ptr);
                    n_ptr     = r_ptr + 1'b1;
                end
            end
            tcw_pkg::S_FILL: begin
                we    = 1'b1;
                waddr = ADDR_W'(r_ptr);
                if (r_ptr == PTR_W'(CELLS - 1)) begin
                    n_row     = ROW_W'(ROWS - 1);
                    n_col     = '0;
                    n_mod     = '0;
                    n_res_scr = 1'b1;
                    n_state   = tcw_pkg::S_DONE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            tcw_pkg::S_DONE: begin
                if (!r_out_valid || pop) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_res_cell;
                    n_out_pos   = tcw_pkg::POS_W'(lin);
                    n_out_scr   = r_res_scr;
                    n_state     = tcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase

        if (r_wr_pend) begin
            we    = 1'b1;
            waddr = r_wr_addr;
            wdata = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_mod       <= '0;
            r_ptr       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_mod       <= n_mod;
            r_ptr       <= n_ptr;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inrange  <= n_inrange;
        r_wr_addr  <= n_wr_addr;
        r_res_cell <= n_res_cell;
        r_res_scr  <= n_res_scr;
        r_out_cell <= n_out_cell;
        r_out_pos  <= n_out_pos;
        r_out_scr  <= n_out_scr;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[raddr];
    end

    assign o_ctl.take     = take;
    assign o_ctl.clearing = (r_state == tcw_pkg::S_CLEAR);
    assign empty          = !r_out_valid;
    assign o_cell_value   = r_out_cell;
    assign o_caret_pos    = r_out_pos;
    assign o_scrolled     = r_out_scr;

    a_idle_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::S_IDLE) |-> (r_row < ROW_W'(ROWS)) && (r_col < COL_W'(COLUMNS)))
        else $error("cursor out of range between requests");

    a_copy_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> ($past(r_state) == tcw_pkg::S_SCRL))
        else $error("copy write outside scroll sweep");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::S_FILL && r_ptr == PTR_W'(CELLS - 1))
        |=> (r_row == ROW_W'(ROWS - 1)) && (r_col == '0) && r_res_scr)
        else $error("scroll did not leave cursor on last row");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::S_CLEAR) |-> !take)
        else $error("request taken during clear sweep");

endmodule

// ----- dv/tb.sv -----
// Testbench for text_console_writer_core: random console traffic checked against a local screen model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = 80;
    localparam int LINES = 25;
    localparam int TABW  = 4;
    localparam int NCELL = COLS * LINES;
    // Watchdog limit for the whole run; a request's worst case is a scroll copy sweep plus fill, plus long stalls.
    localparam int CYCLE_LIMIT = 12000000;

    typedef struct packed {
        logic                      cmd;
        logic [7:0]                char_code;
        logic [tcw_pkg::IDX_W-1:0] read_index;
    } t_req;

    typedef struct packed {
        logic [tcw_pkg::CELL_W-1:0] cell_value;
        logic [tcw_pkg::POS_W-1:0]  caret_pos;
        logic                       scrolled;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic i_cmd = 1'b0;
    logic [7:0] i_char_code = '0;
    logic [tcw_pkg::IDX_W-1:0] i_read_index = '0;
    logic empty;
    logic pop = 1'b0;
    logic [tcw_pkg::CELL_W-1:0] o_cell_value;
    logic [tcw_pkg::POS_W-1:0] o_caret_pos;
    logic o_scrolled;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = '0;

    text_console_writer_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .empty        (empty),
        .pop          (pop),
        .o_cell_value (o_cell_value),
        .o_caret_pos  (o_caret_pos),
        .o_scrolled   (o_scrolled),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Screen model, updated at the moment each request is accepted.
    logic [15:0] scr [NCELL];
    int unsigned cur_col, cur_row;
    logic [7:0] color_reg;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int errors = 0;
    int cycles = 0;
    bit hold_sender = 1'b0;   // when set, the driver holds back new requests; the stimulus never sets it
    int rx_hold = 0;          // long receiver hold-off request, in cycles

    function automatic logic [15:0] blank();
        return {color_reg, tcw_pkg::CH_SPACE};
    endfunction

    // Apply one request to the screen model and return the response it produces.
    function automatic t_rsp console_step(t_req r);
        t_rsp o;
        int unsigned n;
        o = '0;
        if (r.cmd) begin
            if (r.read_index < NCELL) o.cell_value = scr[r.read_index];
        end else begin
            case (r.char_code)
                tcw_pkg::CH_NL: begin
                    cur_col = 0;
                    cur_row++;
                end
                tcw_pkg::CH_CR: cur_col = 0;
                tcw_pkg::CH_TAB: begin
                    n = TABW - (cur_col % TABW);
                    while (n != 0 && cur_col < COLS) begin
                        scr[cur_row * COLS + cur_col] = blank();
                        cur_col++;
                        n--;
                    end
                end
                tcw_pkg::CH_BS: begin
                    if (cur_col > 0 || cur_row > 0) begin
                        if (cur_col > 0) cur_col--;
                        else begin
                            cur_row--;
                            cur_col = COLS - 1;
                        end
                        scr[cur_row * COLS + cur_col] = blank();
                    end
                end
                default: begin
                    scr[cur_row * COLS + cur_col] = {color_reg, r.char_code};
                    cur_col++;
                end
            endcase
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= LINES) begin
                // scroll up one row and clear the bottom row in the current color
                for (int i = 0; i < NCELL - COLS; i++) scr[i] = scr[i + COLS];
                for (int i = NCELL - COLS; i < NCELL; i++) scr[i] = blank();
                cur_row = LINES - 1;
                cur_col = 0;
                o.scrolled = 1'b1;
            end
        end
        o.caret_pos = tcw_pkg::POS_W'(cur_row * COLS + cur_col);
        return o;
    endfunction

    function automatic int gap_len();
        // mostly zero or short, now and then long
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offers requests from pending_reqs; an accepted request updates the model.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                expected_rsps.push_back(console_step(pending_reqs.pop_front()));
                tx_gap = gap_len();
            end
            if (!(push && full)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    push <= 1'b0;
                end else if (pending_reqs.size() > 0 && !hold_sender) begin
                    push <= 1'b1;
                    i_cmd <= pending_reqs[0].cmd;
                    i_char_code <= pending_reqs[0].char_code;
                    i_read_index <= pending_reqs[0].read_index;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge i_clk) begin
        if (rx_hold > 0) rx_hold--;
    end

    // Monitor: pops with random stalls and checks each response in order.
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response cell=%h pos=%0d scr=%0d", $realtime,
                             o_cell_value, o_caret_pos, o_scrolled);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_cell_value !== e.cell_value) begin
                        $display("%0t: cell_value expected %h actual %h", $realtime,
                                 e.cell_value, o_cell_value);
                        errors++;
                    end
                    if (o_caret_pos !== e.caret_pos) begin
                        $display("%0t: caret_pos expected %0d actual %0d", $realtime,
                                 e.caret_pos, o_caret_pos);
                        errors++;
                    end
                    if (o_scrolled !== e.scrolled) begin
                        $display("%0t: scrolled expected %0d actual %0d", $realtime,
                                 e.scrolled, o_scrolled);
                        errors++;
                    end
                end
                rx_gap = gap_len();
            end
            if (rx_hold > 0) begin
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Cycle limit watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_put(logic [7:0] c);
        t_req r;
        r.cmd = 1'b0;
        r.char_code = c;
        r.read_index = tcw_pkg::IDX_W'($urandom_range(0, 2047));
        pending_reqs.push_back(r);
    endtask

    task automatic add_read(logic [tcw_pkg::IDX_W-1:0] idx);
        t_req r;
        r.cmd = 1'b1;
        r.char_code = 8'($urandom_range(0, 255));
        r.read_index = idx;
        pending_reqs.push_back(r);
    endtask

    // Wait until everything queued was accepted and answered, then let a scroll sweep finish.
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (2 * NCELL + 50) @(posedge i_clk);
    endtask

    task automatic set_color(logic [7:0] c);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        color_reg = c;
    endtask

    // One random request; mostly printable text with control codes and reads sprinkled in.
    task automatic add_random();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) add_put(8'($urandom_range(32, 126)));
        else if (k < 55) add_put(8'($urandom_range(0, 255)));
        else if (k < 63) add_put(tcw_pkg::CH_NL);
        else if (k < 67) add_put(tcw_pkg::CH_CR);
        else if (k < 73) add_put(tcw_pkg::CH_TAB);
        else if (k < 80) add_put(tcw_pkg::CH_BS);
        else if (k < 95) add_read(tcw_pkg::IDX_W'($urandom_range(0, NCELL - 1)));
        else add_read(tcw_pkg::IDX_W'($urandom_range(0, 2047)));
    endtask

    initial begin
        logic [7:0] colors [4];
        for (int i = 0; i < NCELL; i++) scr[i] = tcw_pkg::RESET_CELL;
        cur_col = 0;
        cur_row = 0;
        color_reg = tcw_pkg::RESET_COLOR;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: backspace at home, reads of both ends and out of range, all control codes.
        add_put(tcw_pkg::CH_BS);
        add_read('0);
        add_read(tcw_pkg::IDX_W'(NCELL - 1));
        add_read(tcw_pkg::IDX_W'(NCELL));
        add_read(11'h7FF);
        add_put(8'h00);
        add_put(8'hFF);
        add_put(tcw_pkg::CH_TAB);
        add_put(8'h41);
        add_put(tcw_pkg::CH_TAB);
        add_put(tcw_pkg::CH_CR);
        add_put(tcw_pkg::CH_BS);
        add_put(tcw_pkg::CH_NL);
        add_put(tcw_pkg::CH_BS);
        add_read('0);
        add_read(tcw_pkg::IDX_W'(COLS - 1));
        // newlines down to the last row
        for (int i = 0; i < LINES - 1; i++) add_put(tcw_pkg::CH_NL);
        drain();

        colors = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
        foreach (colors[p]) begin
            set_color(colors[p]);
            // wrap at row end, also via a tab at the last column
            for (int i = 0; i < COLS - 1; i++) add_put(8'(8'h61 + i % 26));
            add_put(tcw_pkg::CH_TAB);
            for (int i = 0; i < 150; i++) add_random();
            if (p == 1) begin
                // receiver holds off long while the sender keeps pushing, filling the block
                rx_hold = 400;
            end
            drain();
            // sender pause until all responses arrived is the drain above
        end
        set_color(tcw_pkg::RESET_COLOR);
        for (int i = 0; i < 80; i++) add_random();
        drain();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
